/* hw/rtl/dwcd_pkg.sv */
// Package for the decimal weighted check digit block.
// Holds shared widths, defaults, control structs and the modulo-10 helper.
// Used by every module in hw/rtl; depends on nothing.
package dwcd_pkg;

  localparam int SERIAL_W           = 64;
  localparam int CHECK_W            = 4;
  localparam int DIGIT_W            = 4;
  localparam int DEFAULT_MAX_DIGITS = 20;
  // Bit counter must reach SERIAL_W - 1; digit count (at most 20) fits as well.
  localparam int CNT_W              = $clog2(SERIAL_W);
  // Weighted partial sum: accumulator (0..9) plus digit times three (0..27).
  localparam int PSUM_W             = 6;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Controls from the sequencer to the binary to BCD converter.
  typedef struct packed {
    logic load;   // capture a new serial number and clear the BCD digits
    logic shift;  // one adjust-and-shift step of the conversion
    logic drain;  // move the BCD digits down by one digit
  } conv_ctrl_t;

  // Controls from the sequencer to the weighted accumulator.
  typedef struct packed {
    logic clear;  // zero the running sum and restart the weights at three
    logic step;   // add the current digit with its weight
  } sum_ctrl_t;

  // Reduces a partial sum in 0..39 to 0..9 by a short compare-subtract chain.
  function automatic digit_t mod10(input logic [PSUM_W-1:0] val);
    logic [PSUM_W-1:0] red;
    begin
      if (val >= PSUM_W'(30)) begin
        red = val - PSUM_W'(30);
      end else if (val >= PSUM_W'(20)) begin
        red = val - PSUM_W'(20);
      end else if (val >= PSUM_W'(10)) begin
        red = val - PSUM_W'(10);
      end else begin
        red = val;
      end
      mod10 = red[DIGIT_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/decimal_weighted_check_digit_top.sv */
// Top level of the decimal weighted check digit block.
// Instantiates dwcd_conv and dwcd_wsum under a small sequencer; depends on dwcd_pkg.
//
// Usage:
// The block computes a GS1-style modulo-10 check digit over the decimal digits
// of a 64-bit unsigned serial number. The low decimal digit has weight 3, the
// next weight 1, and so on, alternating; the result is (10 - sum mod 10) mod 10.
// Only the MAX_DIGITS low decimal digits take part.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low; serial_number is sampled at that edge. busy stays high until the result
// has been delivered. The result appears on check_digit for exactly one cycle
// with done high; the receiver cannot stall it and must take it in that cycle.
//
// Steps: the accepting edge loads the serial number, then the shift-and-add-three
// conversion takes one input bit per cycle through the per-digit adjust units,
// then the weighted accumulation takes one digit per cycle, and then done is
// shown. A new transaction can be accepted in the cycle after done, not before.
//
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// drops any transaction in flight; no result is produced for it.
module decimal_weighted_check_digit_top
  import dwcd_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [SERIAL_W-1:0] serial_number,
  output logic                done,
  output logic [CHECK_W-1:0]  check_digit
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(SERIAL_W - 1);
  localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(MAX_DIGITS - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;

  conv_ctrl_t conv_ctrl;
  sum_ctrl_t  sum_ctrl;
  digit_t     digit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  // Sequencer: the converter shifts once per input bit, then the digits are
  // drained into the accumulator one at a time, low digit first.
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    conv_ctrl.load  = 1'b0;
    conv_ctrl.shift = 1'b0;
    conv_ctrl.drain = 1'b0;
    sum_ctrl.clear  = 1'b0;
    sum_ctrl.step   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          conv_ctrl.load = 1'b1;
          sum_ctrl.clear = 1'b1;
          cnt_next       = '0;
          state_next     = ST_CONV;
        end
      end
      ST_CONV: begin
        conv_ctrl.shift = 1'b1;
        if (cnt == CONV_LAST) begin
          cnt_next   = '0;
          state_next = ST_SUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SUM: begin
        conv_ctrl.drain = 1'b1;
        sum_ctrl.step   = 1'b1;
        if (cnt == SUM_LAST) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  dwcd_conv #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk          (clk),
    .ctrl         (conv_ctrl),
    .serial_number(serial_number),
    .low_digit    (digit)
  );

  dwcd_wsum u_wsum (
    .clk        (clk),
    .ctrl       (sum_ctrl),
    .digit      (digit),
    .check_digit(check_digit)
  );

endmodule

/* hw/rtl/dwcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add-three) for the check digit block.
// Keeps only the MAX_DIGITS low decimal digits, which is the value modulo 10**MAX_DIGITS.
// Depends on dwcd_pkg.
module dwcd_conv
  import dwcd_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                clk,
  input  conv_ctrl_t          ctrl,
  input  logic [SERIAL_W-1:0] serial_number,
  output digit_t              low_digit
);

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;

  logic [SERIAL_W-1:0] bin;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;

  // Each digit of five or more gets three added so that the doubling carries
  // into the next digit in decimal.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= serial_number;
      bcd <= '0;
    end else if (ctrl.shift) begin
      bin <= {bin[SERIAL_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[SERIAL_W-1]};
    end else if (ctrl.drain) begin
      bcd <= bcd >> DIGIT_W;
    end
  end

  assign low_digit = bcd[DIGIT_W-1:0];

endmodule

/* hw/rtl/dwcd_wsum.sv */
// Weighted modulo-10 accumulator for the check digit block.
// Adds one digit per step with weights 3, 1, 3, ... and forms the check digit.
// Depends on dwcd_pkg.
module dwcd_wsum
  import dwcd_pkg::*;
(
  input  logic               clk,
  input  sum_ctrl_t          ctrl,
  input  digit_t             digit,
  output logic [CHECK_W-1:0] check_digit
);

  digit_t            acc;
  logic              weight3;
  logic [PSUM_W-1:0] term;
  logic [PSUM_W-1:0] psum;

  always_comb begin
    if (weight3) begin
      term = {2'b00, digit} + {1'b0, digit, 1'b0};
    end else begin
      term = {2'b00, digit};
    end
    psum = term + {2'b00, acc};
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc     <= '0;
      weight3 <= 1'b1;
    end else if (ctrl.step) begin
      acc     <= mod10(psum);
      weight3 <= ~weight3;
    end
  end

  assign check_digit = (acc == '0) ? '0 : CHECK_W'(10) - acc;

endmodule

/* hw/rtl/dwcd_checker.sv */
// Port-level checker for the decimal weighted check digit block, with its bind.
// Watches only the top level's ports; depends on dwcd_pkg.
module dwcd_checker
  import dwcd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [CHECK_W-1:0] check_digit
);

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // A result is shown for one cycle only.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A result belongs to a transaction in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done while the block is idle");

  // The block becomes free only right after delivering its result.
  a_free_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  // The check digit is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (check_digit <= CHECK_W'(9)))
    else $error("check digit out of range");

endmodule

bind decimal_weighted_check_digit_top dwcd_checker u_dwcd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .check_digit(check_digit)
);
